// File: hdl/ilir_pkg.sv
// Shared types and constants for the indexed list block.
package ilir_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int GROUP  = 8;
    localparam int NGRP   = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [POS_W-1:0] DEPTH_C = POS_W'(DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_INSERT    = 3'd1,
        MODE_REMOVE    = 3'd2,
        MODE_READ      = 3'd3,
        MODE_OVERWRITE = 3'd4,
        MODE_RESIZE    = 3'd5
    } t_mode;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_WRITE  = 3'd2,
        CELL_SHIFT  = 3'd3,
        CELL_ZERO   = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  hi;
        logic [WORD_W-1:0] word;
    } t_cell_cmd;

endpackage

// File: hdl/ilir_if.sv
// Request and response channel interfaces for the indexed list block.
interface ilir_req_if import ilir_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  amount;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, mode, position, amount, word_in, input ready);
    modport sink   (input valid, mode, position, amount, word_in, output ready);
endinterface

interface ilir_rsp_if import ilir_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [POS_W-1:0]  length;
    logic [STAT_W-1:0] status;

    modport source (output valid, word_out, length, status, input ready);
    modport sink   (input valid, word_out, length, status, output ready);
endinterface

// File: hdl/ilir_cell.sv
// One list entry cell that takes its word from a neighbor, the request or zero.
module ilir_cell import ilir_pkg::*; (
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  t_cell_cmd         i_cmd,
    input  logic [WORD_W-1:0] i_left,
    input  logic [WORD_W-1:0] i_right,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_read
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [POS_W-1:0]  idx;

    assign idx = POS_W'(i_index);

    always_comb begin
        n_word = r_word;
        unique case (i_cmd.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (idx > i_cmd.pos) begin
                    n_word = i_left;
                end else if (idx == i_cmd.pos) begin
                    n_word = i_cmd.word;
                end
            end
            CELL_WRITE: begin
                if (idx == i_cmd.pos) begin
                    n_word = i_cmd.word;
                end
            end
            CELL_SHIFT: begin
                if (idx >= i_cmd.pos) begin
                    n_word = i_right;
                end
            end
            CELL_ZERO: begin
                if (idx >= i_cmd.pos && idx < i_cmd.hi) begin
                    n_word = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_read = (idx == i_cmd.pos) ? r_word : '0;

endmodule

// File: hdl/indexed_list_insert_remove.sv
// Top level of the indexed list block: request control, cell row and read tree.
// The list lives in a row of 64 cells; each cell holds one word and can take the word of
// its left or right neighbor. One request is handled at a time. Append, insert and resize
// pass through the execute state, and a failed request or a remove of no entries goes
// straight to the done state. Read and overwrite also pass the read state, in which the
// addressed word is taken from a two-stage OR tree whose first stage is registered, and
// remove moves the tail down one place per cycle through the cell row. A finished
// response sits in an output register, and the next request is taken while it waits; a
// request that finishes while that register is still full waits until it is taken.
module indexed_list_insert_remove import ilir_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilir_req_if.sink    i_req,
    ilir_rsp_if.source  o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_shift_cnt;
    logic              r_is_read;
    t_cell_cmd         r_cmd;
    logic [STAT_W-1:0] r_status;
    logic [WORD_W-1:0] r_word;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [POS_W-1:0]  r_out_len;
    logic [STAT_W-1:0] r_out_status;

    logic              accept;
    logic              out_free;
    logic [STAT_W-1:0] acc_status;
    t_cell_cmd         acc_cmd;
    logic              acc_read;
    logic [POS_W:0]    rm_end;

    t_cell_cmd         cell_cmd;
    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_read [DEPTH];
    logic [WORD_W-1:0] r_grp  [NGRP];
    logic [WORD_W-1:0] tree_word;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign rm_end   = {1'b0, i_req.position} + {1'b0, i_req.amount};

    always_comb begin
        acc_status   = ST_OK;
        acc_cmd.op   = CELL_HOLD;
        acc_cmd.pos  = i_req.position;
        acc_cmd.hi   = i_req.amount;
        acc_cmd.word = i_req.word_in;
        acc_read     = 1'b0;
        n_count      = r_count;
        n_state      = S_EXEC;
        unique case (i_req.mode)
            MODE_APPEND: begin
                if (r_count >= DEPTH_C) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_cmd.op  = CELL_WRITE;
                    acc_cmd.pos = r_count;
                    n_count     = r_count + POS_W'(1);
                end
            end
            MODE_INSERT: begin
                if (i_req.position > r_count) begin
                    acc_status = ST_RANGE;
                end else if (r_count >= DEPTH_C) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_cmd.op = CELL_INSERT;
                    n_count    = r_count + POS_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (rm_end > {1'b0, r_count}) begin
                    acc_status = ST_RANGE;
                end else if (i_req.amount != '0) begin
                    acc_cmd.op = CELL_SHIFT;
                    n_count    = r_count - i_req.amount;
                    n_state    = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            MODE_READ: begin
                if (i_req.position >= r_count) begin
                    acc_status = ST_RANGE;
                end else begin
                    acc_read = 1'b1;
                end
            end
            MODE_OVERWRITE: begin
                if (i_req.position >= r_count) begin
                    acc_status = ST_RANGE;
                end else begin
                    acc_cmd.op = CELL_WRITE;
                    acc_read   = 1'b1;
                end
            end
            MODE_RESIZE: begin
                if (i_req.amount > DEPTH_C) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_cmd.op  = CELL_ZERO;
                    acc_cmd.pos = r_count;
                    n_count     = i_req.amount;
                end
            end
            default: begin
                acc_status = ST_RANGE;
            end
        endcase
        if (acc_status != ST_OK) begin
            n_state = S_DONE;
            n_count = r_count;
        end
    end

    always_comb begin
        cell_cmd = r_cmd;
        if (r_state != S_EXEC && r_state != S_SHIFT) begin
            cell_cmd.op = CELL_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= n_state;
                        r_count <= n_count;
                    end
                end
                S_EXEC: begin
                    r_state <= r_is_read ? S_READ : S_DONE;
                end
                S_SHIFT: begin
                    if (r_shift_cnt == POS_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= acc_cmd;
            r_status    <= acc_status;
            r_is_read   <= acc_read;
            r_shift_cnt <= i_req.amount;
            r_word      <= '0;
        end
        if (r_state == S_SHIFT) begin
            r_shift_cnt <= r_shift_cnt - POS_W'(1);
        end
        if (r_state == S_READ) begin
            r_word <= tree_word;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_word   <= r_word;
            r_out_len    <= r_count;
            r_out_status <= r_status;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_inner_l
            assign left_word = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_inner_r
            assign right_word = w_word[g+1];
        end

        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (cell_cmd),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (w_word[g]),
            .o_read  (w_read[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            logic [WORD_W-1:0] acc;
            acc = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    acc = acc | w_read[g*GROUP+k];
                end
            end
            r_grp[g] <= acc;
        end
    end

    always_comb begin
        tree_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            tree_word = tree_word | r_grp[g];
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.word_out = r_out_word;
    assign o_rsp.length   = r_out_len;
    assign o_rsp.status   = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("list length exceeds the number of cells");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while the previous one is still in progress");

    a_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_shift_cnt != '0)
        else $error("shift loop entered with nothing left to move");

    a_fail_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ST_OK |-> o_rsp.word_out == '0)
        else $error("failed request returns a nonzero word");

endmodule
